// ----- src/imhq_pkg.sv -----
// shared types and constants of the indexed max-heap queue
package imhq_pkg;

   localparam int DEPTH = 256;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = AW + 1;
   localparam int HW    = 8;
   localparam int PW    = 32;
   localparam int HANDLES = 1 << HW;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_UPDATE  = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_HANDLE = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [PW-1:0] prio;
      logic [HW-1:0]        handle;
   } entry_type;

   // write request into the two memories, one write enable for each
   typedef struct packed {
      logic          heap_we;
      logic [AW-1:0] heap_waddr;
      entry_type     heap_wdata;
      logic          pos_we;
      logic [HW-1:0] pos_waddr;
      logic [AW-1:0] pos_wdata;
   } store_wr_type;

endpackage

// ----- src/imhq_store.sv -----
// heap entry memory and handle-to-position memory, registered reads
module imhq_store (
   input  logic                        clock,
   input  logic [imhq_pkg::AW-1:0]     heap_raddr,
   output imhq_pkg::entry_type         heap_rdata,
   input  logic [imhq_pkg::HW-1:0]     pos_raddr,
   output logic [imhq_pkg::AW-1:0]     pos_rdata,
   input  imhq_pkg::store_wr_type      wr
);

   imhq_pkg::entry_type         heap_mem [imhq_pkg::DEPTH];
   logic [imhq_pkg::AW-1:0]     pos_mem  [imhq_pkg::HANDLES];

   always_ff @(posedge clock) begin
      if (wr.heap_we) begin
         heap_mem[wr.heap_waddr] <= wr.heap_wdata;
      end
      heap_rdata <= heap_mem[heap_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.pos_we) begin
         pos_mem[wr.pos_waddr] <= wr.pos_wdata;
      end
      pos_rdata <= pos_mem[pos_raddr];
   end

endmodule

// ----- src/indexed_max_heap_queue.sv -----
// indexed binary max-heap priority queue, top level
//
//  channel   dir  handshake              payload
//  req_      in   tvalid/tready          tuser: op | tdata: handle, priority_req, delta
//  rsp_      out  tvalid/tready          tuser: status | tdata: out_handle, out_priority, count
//  csr_      in   apb psel/penable       capacity_limit at byte address 0
//
// one request at a time; a refused request passes through S_TOP, S_TOP_C and S_OUT,
// a sift-up goes through S_UP and S_UP_C for each level moved and a sift-down through
// S_DN, S_DN_R and S_DN_C for each level moved; the single read port of the heap
// memory and its registered read set the per-level cost
// reset is synchronous and needs no clearing pass: the presence bits and the count are
// cleared, and memory read data is used only where written before
// a finished response waits in the output register while the next request runs;
// the sequencer stalls in its last state only if that register is still full
module indexed_max_heap_queue (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // handle[7:0], priority_req[39:8], delta[71:40]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_handle[7:0], out_priority[39:8], count[48:40]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_EX_A, S_EX_B, S_POS, S_UPD, S_RM, S_UP, S_UP_C,
      S_DN, S_DN_R, S_DN_C, S_WR, S_TOP, S_TOP_C, S_OUT
   } state_type;

   localparam int AW = imhq_pkg::AW;
   localparam int CW = imhq_pkg::CW;
   localparam int HW = imhq_pkg::HW;
   localparam int PW = imhq_pkg::PW;

   state_type                     state_ff;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 cap_ff;
   logic [imhq_pkg::HANDLES-1:0]  present_ff;
   imhq_pkg::op_type              op_ff;
   logic [HW-1:0]                 handle_ff;
   logic signed [PW-1:0]          delta_ff;
   imhq_pkg::status_type          status_ff;
   imhq_pkg::entry_type           cur_ff;      // element carried through the sift
   imhq_pkg::entry_type           left_ff;
   imhq_pkg::entry_type           res_ff;
   logic [AW-1:0]                 pos_ff;      // current hole in the heap
   logic                          also_down_ff;
   logic                          moved_ff;
   logic                          keep_res_ff;
   logic                          rsp_valid_ff;
   imhq_pkg::status_type          rsp_status_ff;
   imhq_pkg::entry_type           rsp_entry_ff;
   logic [CW-1:0]                 rsp_count_ff;

   logic [AW-1:0]                 heap_raddr;
   imhq_pkg::entry_type           heap_q;
   logic [AW-1:0]                 pos_q;
   imhq_pkg::store_wr_type        wr;

   imhq_pkg::op_type              req_op;
   logic [HW-1:0]                 req_handle;
   logic [CW-1:0]                 limit;
   logic [CW-1:0]                 last;
   logic [AW-1:0]                 parent;
   logic [CW:0]                   left_idx;
   logic [CW:0]                   right_idx;
   logic                          right_ok;
   logic [AW-1:0]                 big_idx;
   imhq_pkg::entry_type           big;
   logic                          up_move;
   logic                          dn_move;
   logic signed [PW:0]            sum;
   logic signed [PW-1:0]          sat;
   logic                          out_free;
   logic                          csr_wr;

   imhq_store u_store (
      .clock      (clock),
      .heap_raddr (heap_raddr),
      .heap_rdata (heap_q),
      .pos_raddr  (req_handle),
      .pos_rdata  (pos_q),
      .wr         (wr)
   );

   assign req_op     = imhq_pkg::op_type'(req_tuser);
   assign req_handle = req_tdata[7:0];
   assign req_tready = (state_ff == S_IDLE);

   // capacity above the memory depth acts as the depth
   assign limit = (cap_ff > CW'(imhq_pkg::DEPTH)) ? CW'(imhq_pkg::DEPTH) : cap_ff;
   assign last  = count_ff - CW'(1);

   // tree neighbors of the hole
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + (CW+1)'(1);
   assign right_ok  = right_idx < {1'b0, count_ff};

   // larger child, left on a tie
   always_comb begin
      if (right_ok && (heap_q.prio > left_ff.prio)) begin
         big     = heap_q;
         big_idx = right_idx[AW-1:0];
      end else begin
         big     = left_ff;
         big_idx = left_idx[AW-1:0];
      end
   end

   assign up_move = cur_ff.prio > heap_q.prio;
   assign dn_move = big.prio > cur_ff.prio;

   // saturating priority update
   assign sum = {heap_q.prio[PW-1], heap_q.prio} + {delta_ff[PW-1], delta_ff};
   always_comb begin
      if (sum[PW] != sum[PW-1]) begin
         sat = sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
         sat = sum[PW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // memory read address
   always_comb begin
      heap_raddr = '0;
      unique case (state_ff)
         S_EX_A:  heap_raddr = last[AW-1:0];
         S_POS:   heap_raddr = (op_ff == imhq_pkg::OP_UPDATE) ? pos_q : last[AW-1:0];
         S_UP:    heap_raddr = parent;
         S_DN:    heap_raddr = left_idx[AW-1:0];
         S_DN_R:  heap_raddr = right_idx[AW-1:0];
         default: heap_raddr = '0;
      endcase
   end

   // memory writes: an element moves into the hole, or the carried one lands
   always_comb begin
      wr = '0;
      unique case (state_ff)
         S_UP_C: begin
            if (up_move && (pos_ff != '0)) begin
               wr.heap_we    = 1'b1;
               wr.heap_waddr = pos_ff;
               wr.heap_wdata = heap_q;
               wr.pos_we     = 1'b1;
               wr.pos_waddr  = heap_q.handle;
               wr.pos_wdata  = pos_ff;
            end
         end
         S_DN_C: begin
            if (dn_move) begin
               wr.heap_we    = 1'b1;
               wr.heap_waddr = pos_ff;
               wr.heap_wdata = big;
               wr.pos_we     = 1'b1;
               wr.pos_waddr  = big.handle;
               wr.pos_wdata  = pos_ff;
            end
         end
         S_WR: begin
            wr.heap_we    = 1'b1;
            wr.heap_waddr = pos_ff;
            wr.heap_wdata = cur_ff;
            wr.pos_we     = 1'b1;
            wr.pos_waddr  = cur_ff.handle;
            wr.pos_wdata  = pos_ff;
         end
         default: wr = '0;
      endcase
   end

   // configuration port, one register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, cap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CW'(imhq_pkg::DEPTH);
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            cap_ff <= csr_pwdata[CW-1:0];
         end
         // output register loads from the last state, holds while stalled
         rsp_valid_ff <= ((state_ff == S_OUT) && out_free) || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff        <= req_op;
                  handle_ff    <= req_handle;
                  delta_ff     <= req_tdata[71:40];
                  status_ff    <= imhq_pkg::ST_OK;
                  keep_res_ff  <= 1'b0;
                  also_down_ff <= 1'b0;
                  moved_ff     <= 1'b0;
                  unique case (req_op)
                     imhq_pkg::OP_INSERT: begin
                        if (present_ff[req_handle]) begin
                           status_ff <= imhq_pkg::ST_HANDLE;
                           state_ff  <= S_TOP;
                        end else if (count_ff >= limit) begin
                           status_ff <= imhq_pkg::ST_FULL;
                           state_ff  <= S_TOP;
                        end else begin
                           cur_ff.prio   <= req_tdata[39:8];
                           cur_ff.handle <= req_handle;
                           pos_ff        <= count_ff[AW-1:0];
                           count_ff      <= count_ff + CW'(1);
                           present_ff[req_handle] <= 1'b1;
                           state_ff      <= S_UP;
                        end
                     end
                     imhq_pkg::OP_EXTRACT: begin
                        if (count_ff == '0) begin
                           status_ff <= imhq_pkg::ST_EMPTY;
                           state_ff  <= S_TOP;
                        end else begin
                           state_ff  <= S_EX_A;
                        end
                     end
                     default: begin
                        if (!present_ff[req_handle]) begin
                           status_ff <= imhq_pkg::ST_HANDLE;
                           state_ff  <= S_TOP;
                        end else begin
                           if (req_op == imhq_pkg::OP_REMOVE) begin
                              present_ff[req_handle] <= 1'b0;
                           end
                           state_ff <= S_POS;
                        end
                     end
                  endcase
               end
            end
            S_EX_A: begin
               // top arrives, the last element is being read
               res_ff      <= heap_q;
               keep_res_ff <= 1'b1;
               present_ff[heap_q.handle] <= 1'b0;
               count_ff    <= last;
               state_ff    <= S_EX_B;
            end
            S_EX_B: begin
               cur_ff <= heap_q;
               pos_ff <= '0;
               state_ff <= (count_ff == '0) ? S_OUT : S_DN;
            end
            S_POS: begin
               pos_ff <= pos_q;
               if (op_ff == imhq_pkg::OP_UPDATE) begin
                  state_ff <= S_UPD;
               end else begin
                  count_ff <= last;
                  state_ff <= ({1'b0, pos_q} == last) ? S_TOP : S_RM;
               end
            end
            S_UPD: begin
               cur_ff.prio   <= sat;
               cur_ff.handle <= handle_ff;
               if (delta_ff > 0) begin
                  state_ff <= S_UP;
               end else if (delta_ff < 0) begin
                  state_ff <= S_DN;
               end else begin
                  state_ff <= S_WR;
               end
            end
            S_RM: begin
               // last element fills the freed slot, sifts up, or down if it did not move up
               cur_ff       <= heap_q;
               also_down_ff <= 1'b1;
               state_ff     <= S_UP;
            end
            S_UP: begin
               if (pos_ff == '0) begin
                  state_ff <= (also_down_ff && !moved_ff) ? S_DN : S_WR;
               end else begin
                  state_ff <= S_UP_C;
               end
            end
            S_UP_C: begin
               if (up_move) begin
                  pos_ff   <= parent;
                  moved_ff <= 1'b1;
                  state_ff <= S_UP;
               end else begin
                  state_ff <= (also_down_ff && !moved_ff) ? S_DN : S_WR;
               end
            end
            S_DN: begin
               state_ff <= (left_idx >= {1'b0, count_ff}) ? S_WR : S_DN_R;
            end
            S_DN_R: begin
               left_ff  <= heap_q;
               state_ff <= S_DN_C;
            end
            S_DN_C: begin
               if (dn_move) begin
                  pos_ff   <= big_idx;
                  state_ff <= S_DN;
               end else begin
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               state_ff <= keep_res_ff ? S_OUT : S_TOP;
            end
            S_TOP: begin
               state_ff <= S_TOP_C;
            end
            S_TOP_C: begin
               res_ff   <= (count_ff == '0) ? '0 : heap_q;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_entry_ff  <= res_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_entry_ff.prio, rsp_entry_ff.handle};

endmodule

// ----- src/imhq_checker.sv -----
// port-level checks of the indexed max-heap queue, bound to the top level
module imhq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // empty status only with nothing held and a zero top
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == imhq_pkg::ST_EMPTY) |->
         (rsp_tdata[48:40] == 9'd0) && (rsp_tdata[39:0] == 40'd0))
      else $error("empty response with data");

   // a refused request on an empty queue reports a zero top
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[48:40] == 9'd0) && (rsp_tuser != imhq_pkg::ST_OK) |->
         (rsp_tdata[39:0] == 40'd0))
      else $error("top reported on empty queue");

   // count stays within the memory depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[48:40] <= 9'(imhq_pkg::DEPTH)))
      else $error("count above depth");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind indexed_max_heap_queue imhq_checker u_imhq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/indexed_max_heap_queue_tb.sv -----
// self-checking testbench for the indexed max-heap priority queue
module indexed_max_heap_queue_tb;

   localparam logic [2:0] CSR_CAPACITY = 3'd0;   // capacity_limit register
   localparam int         MAX_REPORTS  = 10;

   // one request of the queue
   typedef struct {
      imhq_pkg::op_type            op;
      logic [imhq_pkg::HW-1:0]     handle;
      logic signed [31:0]          prio;
      logic signed [31:0]          delta;
   } heap_request_type;

   // one response of the queue
   typedef struct {
      imhq_pkg::status_type        status;
      logic [imhq_pkg::HW-1:0]     handle;
      logic signed [31:0]          prio;
      logic [8:0]                  count;
   } heap_response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // handle[7:0], priority_req[39:8], delta[71:40]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // out_handle[7:0], out_priority[39:8], count[48:40]
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow copy of the queue contents
   logic signed [31:0]      shadow_prio [imhq_pkg::DEPTH];
   logic [imhq_pkg::HW-1:0] shadow_handle [imhq_pkg::DEPTH];
   int unsigned             shadow_pos [imhq_pkg::HANDLES];
   bit                      shadow_present [imhq_pkg::HANDLES];
   int unsigned             shadow_count;
   int unsigned             shadow_capacity;

   heap_request_type  pending_requests[$];
   heap_response_type expected_responses[$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int responses_checked;
   int op_seen [4];
   int status_seen [4];
   int max_count_seen;

   indexed_max_heap_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // heap predictor
   // ---------------------------------------------------------------------

   // exchange two heap slots and keep the handle map in step
   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic signed [31:0]      tp;
      logic [imhq_pkg::HW-1:0] th;
      tp = shadow_prio[a];
      th = shadow_handle[a];
      shadow_prio[a]   = shadow_prio[b];
      shadow_handle[a] = shadow_handle[b];
      shadow_prio[b]   = tp;
      shadow_handle[b] = th;
      shadow_pos[shadow_handle[a]] = a;
      shadow_pos[shadow_handle[b]] = b;
   endfunction

   // move up past strictly smaller parents only
   function automatic void bubble_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0 && pos < shadow_count) begin
         parent = (pos - 1) / 2;
         if (shadow_prio[pos] <= shadow_prio[parent]) break;
         swap_slots(pos, parent);
         pos = parent;
      end
   endfunction

   // move down toward the larger child, left one on a tie
   function automatic void bubble_down(int unsigned pos);
      int unsigned left;
      int unsigned big;
      while (pos < shadow_count) begin
         left = 2 * pos + 1;
         if (left >= shadow_count) break;
         big = left;
         if (left + 1 < shadow_count && shadow_prio[left + 1] > shadow_prio[left])
            big = left + 1;
         if (shadow_prio[big] <= shadow_prio[pos]) break;
         swap_slots(pos, big);
         pos = big;
      end
   endfunction

   // apply one request to the shadow queue and return the response it gives
   function automatic heap_response_type apply_heap_request(heap_request_type r);
      heap_response_type  rsp;
      int unsigned        limit;
      int unsigned        pos;
      int unsigned        last;
      logic signed [32:0] sum;
      bit                 took_top;
      rsp.status = imhq_pkg::ST_OK;
      rsp.handle = '0;
      rsp.prio   = '0;
      took_top   = 0;
      limit = (shadow_capacity < imhq_pkg::DEPTH) ? shadow_capacity : imhq_pkg::DEPTH;
      case (r.op)
         imhq_pkg::OP_INSERT: begin
            // presence is checked before fullness
            if (shadow_present[r.handle]) begin
               rsp.status = imhq_pkg::ST_HANDLE;
            end else if (shadow_count >= limit) begin
               rsp.status = imhq_pkg::ST_FULL;
            end else begin
               pos = shadow_count;
               shadow_prio[pos]   = r.prio;
               shadow_handle[pos] = r.handle;
               shadow_pos[r.handle] = pos;
               shadow_present[r.handle] = 1;
               shadow_count++;
               bubble_up(pos);
            end
         end
         imhq_pkg::OP_EXTRACT: begin
            if (shadow_count == 0) begin
               rsp.status = imhq_pkg::ST_EMPTY;
            end else begin
               last = shadow_count - 1;
               rsp.handle = shadow_handle[0];
               rsp.prio   = shadow_prio[0];
               took_top   = 1;
               shadow_present[rsp.handle] = 0;
               if (last != 0) begin
                  shadow_prio[0]   = shadow_prio[last];
                  shadow_handle[0] = shadow_handle[last];
                  shadow_pos[shadow_handle[0]] = 0;
               end
               shadow_count = last;
               bubble_down(0);
            end
         end
         imhq_pkg::OP_UPDATE: begin
            if (!shadow_present[r.handle]) begin
               rsp.status = imhq_pkg::ST_HANDLE;
            end else begin
               pos = shadow_pos[r.handle];
               // saturate the sum to the signed 32-bit range
               sum = 33'(shadow_prio[pos]) + 33'(r.delta);
               if (sum > 33'sh0_7FFF_FFFF)
                  shadow_prio[pos] = 32'sh7FFF_FFFF;
               else if (sum < -33'sh0_8000_0000)
                  shadow_prio[pos] = 32'sh8000_0000;
               else
                  shadow_prio[pos] = sum[31:0];
               if (r.delta > 0)
                  bubble_up(pos);
               else if (r.delta < 0)
                  bubble_down(pos);
            end
         end
         default: begin
            if (!shadow_present[r.handle]) begin
               rsp.status = imhq_pkg::ST_HANDLE;
            end else begin
               pos  = shadow_pos[r.handle];
               last = shadow_count - 1;
               shadow_present[r.handle] = 0;
               // last element fills the hole, then moves whichever way it must
               if (pos != last) begin
                  shadow_prio[pos]   = shadow_prio[last];
                  shadow_handle[pos] = shadow_handle[last];
                  shadow_pos[shadow_handle[pos]] = pos;
               end
               shadow_count = last;
               if (pos < shadow_count) begin
                  bubble_up(pos);
                  bubble_down(pos);
               end
            end
         end
      endcase
      // everything but a successful extract reports the current top
      if (!took_top && shadow_count > 0) begin
         rsp.handle = shadow_handle[0];
         rsp.prio   = shadow_prio[0];
      end
      rsp.count = 9'(shadow_count);
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: feeds pending requests, idles at random
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      heap_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            nxt.op     = imhq_pkg::op_type'(req_tuser);
            nxt.handle = req_tdata[7:0];
            nxt.prio   = req_tdata[39:8];
            nxt.delta  = req_tdata[71:40];
            expected_responses.push_back(apply_heap_request(nxt));
            op_seen[req_tuser]++;
         end
         // a request on the bus stays until taken
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= {nxt.delta, nxt.prio, nxt.handle};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      heap_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: status %0d handle %0d prio %0d count %0d",
                        rsp_tuser, rsp_tdata[7:0], $signed(rsp_tdata[39:8]),
                        rsp_tdata[48:40]);
         end else begin
            want = expected_responses.pop_front();
            responses_checked++;
            status_seen[want.status]++;
            if (want.count > max_count_seen) max_count_seen = want.count;
            if (rsp_tuser != want.status || rsp_tdata[7:0] != want.handle ||
                rsp_tdata[39:8] != want.prio || rsp_tdata[48:40] != want.count) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $write("response %0d mismatch (expected/actual): status %0d/%0d",
                         responses_checked, want.status, rsp_tuser);
                  $display(" handle %0d/%0d prio %0d/%0d count %0d/%0d",
                           want.handle, rsp_tdata[7:0], want.prio,
                           $signed(rsp_tdata[39:8]), want.count, rsp_tdata[48:40]);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void queue_request(imhq_pkg::op_type op, int handle,
                                         logic signed [31:0] prio,
                                         logic signed [31:0] delta);
      heap_request_type r;
      r.op     = op;
      r.handle = 8'(handle);
      r.prio   = prio;
      r.delta  = delta;
      pending_requests.push_back(r);
   endfunction

   // priority or delta: full range, extremes, or a narrow band for ties
   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return $urandom;
      if (sel < 6) return 32'($signed($urandom_range(8)) - 4);
      if (sel == 6) return 32'sh7FFF_FFFF;
      if (sel == 7) return 32'sh8000_0000;
      return 32'($signed($urandom_range(2000)) - 1000);
   endfunction

   // held handle most of the time so update and remove do real work
   function automatic int pick_handle(bit prefer_held);
      int held [$];
      for (int h = 0; h < imhq_pkg::HANDLES; h++)
         if (shadow_present[h]) held.push_back(h);
      if (prefer_held && held.size() > 0 && $urandom_range(99) < 85)
         return held[$urandom_range(held.size() - 1)];
      return $urandom_range(imhq_pkg::HANDLES - 1);
   endfunction

   function automatic void queue_random_request();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35)
         queue_request(imhq_pkg::OP_INSERT, pick_handle(0), pick_value(), '0);
      else if (sel < 55)
         queue_request(imhq_pkg::OP_EXTRACT, $urandom_range(imhq_pkg::HANDLES - 1),
                       $urandom, $urandom);
      else if (sel < 80)
         queue_request(imhq_pkg::OP_UPDATE, pick_handle(1), $urandom, pick_value());
      else
         queue_request(imhq_pkg::OP_REMOVE, pick_handle(1), $urandom, $urandom);
   endfunction

   // sender holds off until every response is back, then lets the block settle;
   // checked between edges so the driver's updates are already visible
   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CAPACITY;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      shadow_capacity = value & 9'h1FF;
   endtask

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
         default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned caps [8];
      int          order [imhq_pkg::HANDLES];
      int          j;
      int          t;
      caps = '{256, 3, 511, 40, 1, 256, 17, 256};
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      responses_checked = 0;
      max_count_seen = 0;
      for (int i = 0; i < 4; i++) begin
         op_seen[i] = 0;
         status_seen[i] = 0;
      end
      for (int h = 0; h < imhq_pkg::HANDLES; h++) shadow_present[h] = 0;
      shadow_count = 0;
      shadow_capacity = 256;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue errors, extremes, ties, saturation, zero delta
      queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      queue_request(imhq_pkg::OP_UPDATE, 5, 0, 1);
      queue_request(imhq_pkg::OP_REMOVE, 255, 0, 0);
      queue_request(imhq_pkg::OP_INSERT, 0, 32'sh7FFF_FFFF, 0);
      queue_request(imhq_pkg::OP_INSERT, 255, 32'sh8000_0000, 0);
      queue_request(imhq_pkg::OP_INSERT, 0, 7, 0);                  // already held
      queue_request(imhq_pkg::OP_INSERT, 1, 32'sh7FFF_FFFF, 0);     // tie with the top
      queue_request(imhq_pkg::OP_INSERT, 2, 0, 0);
      queue_request(imhq_pkg::OP_UPDATE, 1, 0, 32'sh7FFF_FFFF);     // saturates high
      queue_request(imhq_pkg::OP_UPDATE, 255, 0, 32'sh8000_0000);   // saturates low
      queue_request(imhq_pkg::OP_UPDATE, 2, 0, 0);                  // zero delta
      queue_request(imhq_pkg::OP_UPDATE, 255, 0, 32'sh7FFF_FFFF);
      queue_request(imhq_pkg::OP_UPDATE, 0, 0, 32'sh8000_0000);
      queue_request(imhq_pkg::OP_REMOVE, 1, 0, 0);
      queue_request(imhq_pkg::OP_REMOVE, 1, 0, 0);                  // already gone
      queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      queue_request(imhq_pkg::OP_REMOVE, 0, 0, 0);                  // already extracted
      queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      wait_drained();

      // capacity of zero refuses everything, capacity of one holds one element
      write_capacity(0);
      queue_request(imhq_pkg::OP_INSERT, 9, 100, 0);
      wait_drained();
      write_capacity(1);
      queue_request(imhq_pkg::OP_INSERT, 9, 100, 0);
      queue_request(imhq_pkg::OP_INSERT, 10, 200, 0);
      queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      wait_drained();

      // random phases across capacities and idling patterns
      for (int phase = 0; phase < 8; phase++) begin
         set_idling(phase);
         write_capacity(caps[phase]);
         for (int n = 0; n < 150; n++) begin
            // short lookahead keeps handle choices close to the live contents
            while (pending_requests.size() > 4) @(posedge clock);
            queue_random_request();
         end
         wait_drained();
      end

      // empty the queue, fill all handles in random order, mix in random requests, then drain by extraction
      write_capacity(256);
      send_idle_pct  = 12;
      recv_stall_pct = 12;
      while (shadow_count > 0) begin
         queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
         wait_drained();
      end
      for (int h = 0; h < imhq_pkg::HANDLES; h++) order[h] = h;
      for (int h = imhq_pkg::HANDLES - 1; h > 0; h--) begin
         j = $urandom_range(h);
         t = order[h];
         order[h] = order[j];
         order[j] = t;
      end
      for (int h = 0; h < imhq_pkg::HANDLES; h++)
         queue_request(imhq_pkg::OP_INSERT, order[h], pick_value(), 0);
      // all handles held
      queue_request(imhq_pkg::OP_INSERT, $urandom_range(imhq_pkg::HANDLES - 1), 0, 0);
      for (int h = 0; h < 40; h++) queue_random_request();
      for (int h = 0; h <= imhq_pkg::HANDLES; h++)
         queue_request(imhq_pkg::OP_EXTRACT, 0, 0, 0);
      wait_drained();

      $display("checked %0d responses: %0d insert, %0d extract, %0d update, %0d remove",
               responses_checked, op_seen[imhq_pkg::OP_INSERT],
               op_seen[imhq_pkg::OP_EXTRACT], op_seen[imhq_pkg::OP_UPDATE],
               op_seen[imhq_pkg::OP_REMOVE]);
      $display("status ok %0d, empty %0d, full %0d, bad handle %0d; peak count %0d",
               status_seen[imhq_pkg::ST_OK], status_seen[imhq_pkg::ST_EMPTY],
               status_seen[imhq_pkg::ST_FULL], status_seen[imhq_pkg::ST_HANDLE],
               max_count_seen);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #8000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
